// ===== src/swarq_pkg.sv =====
// ----------------------------------------------------------------------------
// swarq_pkg: shared definitions for the sliding window ARQ transmitter
// Command and result codes, register map and reset values.
// ----------------------------------------------------------------------------
`default_nettype none

package swarq_pkg;

	localparam int WINDOW_SIZE_DEF = 8;

	localparam int CMD_W     = 3;
	localparam int HANDLE_W  = 16;
	localparam int SEQ_W     = 32;
	localparam int CHAN_W    = 8;
	localparam int TICKS_W   = 16;
	localparam int APB_DW    = 32;
	localparam int APB_AW    = 3;

	localparam logic [CHAN_W-1:0]  CHAN_RESET  = 8'd0;
	localparam logic [TICKS_W-1:0] RETX_RESET  = 16'd500;
	localparam logic [SEQ_W-1:0]   SEQ_RESET   = 32'd1;

	// register index, taken from paddr[2]
	localparam logic REG_CHANNEL_ID = 1'b0;
	localparam logic REG_RETX_TICKS = 1'b1;

	typedef enum logic [CMD_W-1:0] {
		CMD_DATA     = 3'd0,
		CMD_ACK      = 3'd1,
		CMD_QUENCH   = 3'd2,
		CMD_UNQUENCH = 3'd3,
		CMD_TICK     = 3'd4
	} cmd_t;

	typedef enum logic [1:0] {
		KIND_NET_DATA  = 2'd0,
		KIND_APP_QUENCH = 2'd1,
		KIND_APP_UNQUENCH = 2'd2,
		KIND_DROPPED   = 2'd3
	} kind_t;

	typedef struct packed {
		kind_t                kind;
		logic [CHAN_W-1:0]    channel;
		logic [SEQ_W-1:0]     seqno;
		logic [HANDLE_W-1:0]  payload;
	} res_t;

	typedef enum logic [10:0] {
		ST_IDLE   = 11'b000_0000_0001,
		ST_DSCAN  = 11'b000_0000_0010,
		ST_DPOST  = 11'b000_0000_0100,
		ST_DROP   = 11'b000_0000_1000,
		ST_QUENCH = 11'b000_0001_0000,
		ST_UNQ    = 11'b000_0010_0000,
		ST_ARD    = 11'b000_0100_0000,
		ST_AEV    = 11'b000_1000_0000,
		ST_TRD    = 11'b001_0000_0000,
		ST_TEV    = 11'b010_0000_0000,
		ST_FIN    = 11'b100_0000_0000
	} state_t;

endpackage

`default_nettype wire

// ===== src/sliding_window_arq_transmitter.sv =====
// ----------------------------------------------------------------------------
// sliding_window_arq_transmitter
// Transmit side of a windowed ARQ link: numbers, stores, sends and resends
// application items, frees them on ack, and raises quench/unquench.
// ----------------------------------------------------------------------------
//  channel   direction  handshake              payload
//  apb       in/out     psel/penable/pready    paddr, pwdata, prdata
//  in        in         in_valid/in_ready      command, payload_handle, ack_seqno
//  out       out        out_valid/out_ready    kind, channel, seqno, payload_out, last
//
//  One item at a time under a sequencer; an ack or tick walk reads the entry
//  memories slot by slot, each slot in a read state and then an evaluate state.
//  Data scans the valid bits for a free slot and may then raise a quench or
//  unquench; dropped data reports the drop and a quench; ack and tick walk the
//  window, and a tick may add an unquench on its first expiry.
//  Reset clears valid bits, counters and flags; entry memories are not cleared.
//  A stalled output holds the sequencer; one result waits in the output
//  register and one in a holding register so that last can be set.
// ----------------------------------------------------------------------------
`default_nettype none

module sliding_window_arq_transmitter #(
	parameter int WINDOW_SIZE = swarq_pkg::WINDOW_SIZE_DEF
) (
	input  wire logic                             clk,
	input  wire logic                             arst_n,
	input  wire logic                             psel,
	input  wire logic                             penable,
	input  wire logic                             pwrite,
	input  wire logic [swarq_pkg::APB_AW-1:0]     paddr,
	input  wire logic [swarq_pkg::APB_DW-1:0]     pwdata,
	output logic      [swarq_pkg::APB_DW-1:0]     prdata,
	output logic                                  pready,
	input  wire logic                             in_valid,
	output logic                                  in_ready,
	input  wire logic [swarq_pkg::CMD_W-1:0]      command,
	input  wire logic [swarq_pkg::HANDLE_W-1:0]   payload_handle,
	input  wire logic [swarq_pkg::SEQ_W-1:0]      ack_seqno,
	output logic                                  out_valid,
	input  wire logic                             out_ready,
	output logic      [1:0]                       kind,
	output logic      [swarq_pkg::CHAN_W-1:0]     channel,
	output logic      [swarq_pkg::SEQ_W-1:0]      seqno,
	output logic      [swarq_pkg::HANDLE_W-1:0]   payload_out,
	output logic                                  last
);

	import swarq_pkg::*;

	localparam int IDX_W = (WINDOW_SIZE > 1) ? $clog2(WINDOW_SIZE) : 1;
	localparam int CNT_W = $clog2(WINDOW_SIZE + 1);
	localparam logic [IDX_W-1:0] IDX_LAST = IDX_W'(WINDOW_SIZE - 1);
	localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(WINDOW_SIZE);

	// configuration
	logic [CHAN_W-1:0]  chan_q;
	logic [TICKS_W-1:0] retx_q;
	logic               cfg_wr;

	// control state
	state_t             state_q, state_d;
	logic [IDX_W-1:0]   idx_q, idx_d;
	logic [CNT_W-1:0]   count_q, count_d;
	logic [WINDOW_SIZE-1:0] valid_q, valid_d;
	logic [SEQ_W-1:0]   next_seq_q, next_seq_d;
	logic               app_blk_q, app_blk_d;
	logic               net_blk_q, net_blk_d;
	logic               first_q, first_d;

	// latched item
	logic [CMD_W-1:0]    cmd_q;
	logic [HANDLE_W-1:0] handle_q;
	logic [SEQ_W-1:0]    ack_q;

	// entry memories
	logic [SEQ_W-1:0]    seq_mem [WINDOW_SIZE];
	logic [HANDLE_W-1:0] pay_mem [WINDOW_SIZE];
	logic [TICKS_W-1:0]  cnt_mem [WINDOW_SIZE];
	logic [SEQ_W-1:0]    seq_rd_q;
	logic [HANDLE_W-1:0] pay_rd_q;
	logic [TICKS_W-1:0]  cnt_rd_q;
	logic                ent_wr;
	logic                cnt_wr;
	logic [TICKS_W-1:0]  cnt_wval;

	// result path
	res_t  pend_q, out_res_q, emit_res;
	logic  pend_valid_q;
	logic  out_valid_q, out_last_q;
	logic  emit_req, emit_ok, fin_push, out_free, load_out;
	logic  in_acc;
	logic  full;
	logic  slot_valid;

	// ------------------------------------------------------------------ apb
	assign pready = 1'b1;
	assign cfg_wr = psel && penable && pwrite;

	always_comb begin
		case (paddr[2])
			REG_CHANNEL_ID: prdata = {{(APB_DW-CHAN_W){1'b0}}, chan_q};
			REG_RETX_TICKS: prdata = {{(APB_DW-TICKS_W){1'b0}}, retx_q};
			default:        prdata = '0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			chan_q <= CHAN_RESET;
			retx_q <= RETX_RESET;
		end else if (cfg_wr) begin
			case (paddr[2])
				REG_CHANNEL_ID: chan_q <= pwdata[CHAN_W-1:0];
				REG_RETX_TICKS: retx_q <= pwdata[TICKS_W-1:0];
				default: ;
			endcase
		end
	end

	// ------------------------------------------------------------ sequencer
	assign in_ready   = (state_q == ST_IDLE);
	assign in_acc     = in_valid && in_ready;
	assign full       = (count_q >= CNT_FULL);
	assign slot_valid = valid_q[idx_q];
	assign out_free   = !out_valid_q || out_ready;
	assign emit_ok    = !pend_valid_q || out_free;

	always_comb begin
		state_d    = state_q;
		idx_d      = idx_q;
		count_d    = count_q;
		valid_d    = valid_q;
		next_seq_d = next_seq_q;
		app_blk_d  = app_blk_q;
		net_blk_d  = net_blk_q;
		first_d    = first_q;
		emit_req   = 1'b0;
		emit_res   = '0;
		fin_push   = 1'b0;
		ent_wr     = 1'b0;
		cnt_wr     = 1'b0;
		cnt_wval   = retx_q;

		case (state_q)
			ST_IDLE: begin
				if (in_acc) begin
					idx_d   = '0;
					first_d = 1'b1;
					case (command)
						CMD_DATA:     state_d = full ? ST_DROP : ST_DSCAN;
						CMD_ACK:      state_d = ST_ARD;
						CMD_QUENCH:   state_d = ST_QUENCH;
						CMD_UNQUENCH: state_d = ST_UNQ;
						CMD_TICK:     state_d = ST_TRD;
						default:      state_d = ST_IDLE;
					endcase
				end
			end

			ST_DSCAN: begin
				if (!slot_valid) begin
					if (net_blk_q || emit_ok) begin
						ent_wr          = 1'b1;
						valid_d[idx_q]  = 1'b1;
						count_d         = count_q + CNT_W'(1);
						next_seq_d      = next_seq_q + SEQ_W'(1);
						emit_req        = !net_blk_q;
						emit_res.kind    = KIND_NET_DATA;
						emit_res.channel = chan_q;
						emit_res.seqno   = next_seq_q;
						emit_res.payload = handle_q;
						state_d         = ST_DPOST;
					end
				end else if (idx_q == IDX_LAST) begin
					state_d = ST_FIN;
				end else begin
					idx_d = idx_q + IDX_W'(1);
				end
			end

			ST_DPOST: begin
				if (full)
					state_d = ST_QUENCH;
				else if (app_blk_q)
					state_d = ST_UNQ;
				else
					state_d = ST_FIN;
			end

			ST_DROP: begin
				if (emit_ok) begin
					emit_req       = 1'b1;
					emit_res.kind  = KIND_DROPPED;
					emit_res.seqno = next_seq_q;
					state_d        = ST_QUENCH;
				end
			end

			ST_QUENCH: begin
				if (emit_ok) begin
					emit_req      = 1'b1;
					emit_res.kind = KIND_APP_QUENCH;
					app_blk_d     = 1'b1;
					if (cmd_q == CMD_QUENCH)
						net_blk_d = 1'b1;
					state_d       = ST_FIN;
				end
			end

			ST_UNQ: begin
				if (emit_ok) begin
					emit_req      = 1'b1;
					emit_res.kind = KIND_APP_UNQUENCH;
					app_blk_d     = 1'b0;
					if (cmd_q == CMD_UNQUENCH)
						net_blk_d = 1'b0;
					if (cmd_q != CMD_TICK)
						state_d = ST_FIN;
					else if (idx_q == IDX_LAST)
						state_d = ST_FIN;
					else begin
						idx_d   = idx_q + IDX_W'(1);
						state_d = ST_TRD;
					end
				end
			end

			ST_ARD: state_d = ST_AEV;

			ST_AEV: begin
				if (slot_valid && seq_rd_q == ack_q) begin
					valid_d[idx_q] = 1'b0;
					count_d        = count_q - CNT_W'(1);
					state_d        = ST_FIN;
				end else if (idx_q == IDX_LAST) begin
					state_d = ST_FIN;
				end else begin
					idx_d   = idx_q + IDX_W'(1);
					state_d = ST_ARD;
				end
			end

			ST_TRD: state_d = ST_TEV;

			ST_TEV: begin
				if (!slot_valid || cnt_rd_q > TICKS_W'(1)) begin
					// count down, then advance
					if (slot_valid) begin
						cnt_wr   = 1'b1;
						cnt_wval = cnt_rd_q - TICKS_W'(1);
					end
					if (idx_q == IDX_LAST)
						state_d = ST_FIN;
					else begin
						idx_d   = idx_q + IDX_W'(1);
						state_d = ST_TRD;
					end
				end else if (net_blk_q || emit_ok) begin
					// expired: rearm, and resend unless the network is quenched
					cnt_wr           = 1'b1;
					emit_req         = !net_blk_q;
					emit_res.kind    = KIND_NET_DATA;
					emit_res.channel = chan_q;
					emit_res.seqno   = seq_rd_q;
					emit_res.payload = pay_rd_q;
					first_d          = 1'b0;
					if (first_q && app_blk_q && !full)
						state_d = ST_UNQ;
					else if (idx_q == IDX_LAST)
						state_d = ST_FIN;
					else begin
						idx_d   = idx_q + IDX_W'(1);
						state_d = ST_TRD;
					end
				end
			end

			ST_FIN: begin
				// release the held result with last set
				if (!pend_valid_q)
					state_d = ST_IDLE;
				else if (out_free) begin
					fin_push = 1'b1;
					state_d  = ST_IDLE;
				end
			end

			default: state_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= ST_IDLE;
			idx_q      <= '0;
			count_q    <= '0;
			valid_q    <= '0;
			next_seq_q <= SEQ_RESET;
			app_blk_q  <= 1'b0;
			net_blk_q  <= 1'b0;
			first_q    <= 1'b0;
		end else begin
			state_q    <= state_d;
			idx_q      <= idx_d;
			count_q    <= count_d;
			valid_q    <= valid_d;
			next_seq_q <= next_seq_d;
			app_blk_q  <= app_blk_d;
			net_blk_q  <= net_blk_d;
			first_q    <= first_d;
		end
	end

	always_ff @(posedge clk) begin
		if (in_acc) begin
			cmd_q    <= command;
			handle_q <= payload_handle;
			ack_q    <= ack_seqno;
		end
	end

	// ------------------------------------------------------- entry memories
	always_ff @(posedge clk) begin
		seq_rd_q <= seq_mem[idx_q];
		pay_rd_q <= pay_mem[idx_q];
		cnt_rd_q <= cnt_mem[idx_q];
		if (ent_wr) begin
			seq_mem[idx_q] <= next_seq_q;
			pay_mem[idx_q] <= handle_q;
		end
		if (ent_wr || cnt_wr)
			cnt_mem[idx_q] <= cnt_wval;
	end

	// ---------------------------------------------------------- result path
	assign load_out = (emit_req && pend_valid_q) || fin_push;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pend_valid_q <= 1'b0;
			out_valid_q  <= 1'b0;
		end else begin
			if (emit_req)
				pend_valid_q <= 1'b1;
			else if (fin_push)
				pend_valid_q <= 1'b0;
			if (load_out)
				out_valid_q <= 1'b1;
			else if (out_ready)
				out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (emit_req)
			pend_q <= emit_res;
		if (load_out) begin
			out_res_q  <= pend_q;
			out_last_q <= fin_push;
		end
	end

	assign out_valid   = out_valid_q;
	assign kind        = out_res_q.kind;
	assign channel     = out_res_q.channel;
	assign seqno       = out_res_q.seqno;
	assign payload_out = out_res_q.payload;
	assign last        = out_last_q;

endmodule

`default_nettype wire

// ===== dv/tb_sliding_window_arq_transmitter.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_sliding_window_arq_transmitter
// Self-checking bench: a scoreboard class models the window store and works
// out the frames each accepted command should cause. Directed corner cases
// come first, then bursty random traffic under several register settings.
// The output side stalls on a shifting pattern.
// ----------------------------------------------------------------------------

import swarq_pkg::*;

class arq_tx_scoreboard;

	typedef struct packed {
		kind_t                kind;
		logic [CHAN_W-1:0]    chan;
		logic [SEQ_W-1:0]     seq;
		logic [HANDLE_W-1:0]  handle;
		logic                 last;
	} frame_t;

	frame_t frames_due[$];
	frame_t batch[$];
	int unsigned mismatches;

	logic [CHAN_W-1:0]   chan_cfg;
	logic [TICKS_W-1:0]  retx_cfg;

	bit                  slot_busy   [WINDOW_SIZE_DEF];
	logic [SEQ_W-1:0]    slot_seq    [WINDOW_SIZE_DEF];
	logic [HANDLE_W-1:0] slot_handle [WINDOW_SIZE_DEF];
	logic [TICKS_W-1:0]  slot_timer  [WINDOW_SIZE_DEF];
	logic [SEQ_W-1:0]    next_seq;
	int unsigned         held;
	bit                  net_hold;
	bit                  app_hold;

	function new();
		chan_cfg = CHAN_RESET;
		retx_cfg = RETX_RESET;
		next_seq = SEQ_RESET;
		held = 0;
		net_hold = 1'b0;
		app_hold = 1'b0;
		mismatches = 0;
		for (int i = 0; i < WINDOW_SIZE_DEF; i++) begin
			slot_busy[i] = 1'b0;
			slot_seq[i] = '0;
			slot_handle[i] = '0;
			slot_timer[i] = '0;
		end
	endfunction

	function void add_frame(kind_t k, logic [CHAN_W-1:0] ch, logic [SEQ_W-1:0] sq,
			logic [HANDLE_W-1:0] hd);
		frame_t f;
		f.kind = k;
		f.chan = ch;
		f.seq = sq;
		f.handle = hd;
		f.last = 1'b0;
		batch.push_back(f);
	endfunction

	// a quenched network still rearms the slot, it only suppresses the frame
	function void send_slot(int slot);
		if (!net_hold)
			add_frame(KIND_NET_DATA, chan_cfg, slot_seq[slot], slot_handle[slot]);
	endfunction

	function logic [SEQ_W-1:0] random_held_seqno();
		int slot;
		slot = $urandom_range(0, WINDOW_SIZE_DEF - 1);
		while (!slot_busy[slot])
			slot = (slot + 1) % WINDOW_SIZE_DEF;
		return slot_seq[slot];
	endfunction

	function void note_command(logic [CMD_W-1:0] cmd, logic [HANDLE_W-1:0] hd,
			logic [SEQ_W-1:0] ack);
		int  slot;
		bit  found;
		bit  first_expiry;
		frame_t f;
		batch.delete();
		found = 1'b0;
		slot = 0;
		case (cmd)
			CMD_DATA: begin
				if (held >= WINDOW_SIZE_DEF) begin
					// drop: the number it would have got is not used up
					add_frame(KIND_DROPPED, '0, next_seq, '0);
					add_frame(KIND_APP_QUENCH, '0, '0, '0);
					app_hold = 1'b1;
				end else begin
					for (int i = 0; i < WINDOW_SIZE_DEF; i++)
						if (!found && !slot_busy[i]) begin
							slot = i;
							found = 1'b1;
						end
					slot_busy[slot] = 1'b1;
					slot_seq[slot] = next_seq;
					slot_handle[slot] = hd;
					slot_timer[slot] = retx_cfg;
					next_seq = next_seq + 1;
					held++;
					send_slot(slot);
					if (held >= WINDOW_SIZE_DEF) begin
						add_frame(KIND_APP_QUENCH, '0, '0, '0);
						app_hold = 1'b1;
					end
					if (app_hold && held < WINDOW_SIZE_DEF) begin
						add_frame(KIND_APP_UNQUENCH, '0, '0, '0);
						app_hold = 1'b0;
					end
				end
			end
			CMD_ACK: begin
				// lowest matching slot wins
				for (int i = 0; i < WINDOW_SIZE_DEF; i++)
					if (!found && slot_busy[i] && slot_seq[i] == ack) begin
						slot_busy[i] = 1'b0;
						found = 1'b1;
						if (held > 0)
							held--;
					end
			end
			CMD_QUENCH: begin
				add_frame(KIND_APP_QUENCH, '0, '0, '0);
				app_hold = 1'b1;
				net_hold = 1'b1;
			end
			CMD_UNQUENCH: begin
				add_frame(KIND_APP_UNQUENCH, '0, '0, '0);
				app_hold = 1'b0;
				net_hold = 1'b0;
			end
			CMD_TICK: begin
				first_expiry = 1'b1;
				for (int i = 0; i < WINDOW_SIZE_DEF; i++)
					if (slot_busy[i]) begin
						if (slot_timer[i] > 1)
							slot_timer[i] = slot_timer[i] - 1;
						else begin
							slot_timer[i] = retx_cfg;
							send_slot(i);
							if (first_expiry) begin
								first_expiry = 1'b0;
								if (app_hold && held < WINDOW_SIZE_DEF) begin
									add_frame(KIND_APP_UNQUENCH, '0, '0, '0);
									app_hold = 1'b0;
								end
							end
						end
					end
			end
			default: ;
		endcase
		for (int i = 0; i < batch.size(); i++) begin
			f = batch[i];
			f.last = (i == batch.size() - 1);
			frames_due.push_back(f);
		end
	endfunction

	function void record_mismatch(string what, frame_t want, frame_t got);
		mismatches++;
		if (mismatches <= 10)
			$display({"[%0t] %s: expected kind=%0d chan=%0h seq=%0h handle=%0h last=%0b,",
				" got kind=%0d chan=%0h seq=%0h handle=%0h last=%0b"},
				$time, what, want.kind, want.chan, want.seq, want.handle, want.last,
				got.kind, got.chan, got.seq, got.handle, got.last);
	endfunction

	function void check_result(logic [1:0] k, logic [CHAN_W-1:0] ch, logic [SEQ_W-1:0] sq,
			logic [HANDLE_W-1:0] hd, logic lst);
		frame_t got;
		frame_t want;
		got.kind = kind_t'(k);
		got.chan = ch;
		got.seq = sq;
		got.handle = hd;
		got.last = lst;
		if (frames_due.size() == 0) begin
			want = '0;
			record_mismatch("unexpected frame", want, got);
		end else begin
			want = frames_due.pop_front();
			if (got.kind !== want.kind || got.chan !== want.chan || got.seq !== want.seq ||
					got.handle !== want.handle || got.last !== want.last)
				record_mismatch("frame mismatch", want, got);
		end
	endfunction

endclass

module tb_sliding_window_arq_transmitter;

	localparam int CYCLE_LIMIT   = 400000;
	localparam int SETTLE_CYCLES = 4 * WINDOW_SIZE_DEF + 8;
	localparam logic [CMD_W-1:0]  CMD_FIRST_UNUSED = 3'd5;
	localparam logic [CMD_W-1:0]  CMD_MID_UNUSED   = 3'd6;
	localparam logic [CMD_W-1:0]  CMD_LAST_UNUSED  = 3'd7;
	localparam logic [APB_AW-1:0] ADDR_CHANNEL_ID  = {REG_CHANNEL_ID, 2'b00};
	localparam logic [APB_AW-1:0] ADDR_RETX_TICKS  = {REG_RETX_TICKS, 2'b00};

	logic                clk;
	logic                arst_n = 1'b0;
	logic                psel = 1'b0;
	logic                penable = 1'b0;
	logic                pwrite = 1'b0;
	logic [APB_AW-1:0]   paddr = '0;
	logic [APB_DW-1:0]   pwdata = '0;
	logic [APB_DW-1:0]   prdata;
	logic                pready;
	logic                in_valid = 1'b0;
	logic                in_ready;
	logic [CMD_W-1:0]    command = CMD_TICK;
	logic [HANDLE_W-1:0] payload_handle = '0;
	logic [SEQ_W-1:0]    ack_seqno = '0;
	logic                out_valid;
	logic                out_ready = 1'b0;
	logic [1:0]          kind;
	logic [CHAN_W-1:0]   channel;
	logic [SEQ_W-1:0]    seqno;
	logic [HANDLE_W-1:0] payload_out;
	logic                last;

	logic [31:0] cycle_count = '0;
	logic [15:0] stall_lfsr = 16'hACE1;

	arq_tx_scoreboard sb = new();

	sliding_window_arq_transmitter uut (
		.clk            (clk),
		.arst_n         (arst_n),
		.psel           (psel),
		.penable        (penable),
		.pwrite         (pwrite),
		.paddr          (paddr),
		.pwdata         (pwdata),
		.prdata         (prdata),
		.pready         (pready),
		.in_valid       (in_valid),
		.in_ready       (in_ready),
		.command        (command),
		.payload_handle (payload_handle),
		.ack_seqno      (ack_seqno),
		.out_valid      (out_valid),
		.out_ready      (out_ready),
		.kind           (kind),
		.channel        (channel),
		.seqno          (seqno),
		.payload_out    (payload_out),
		.last           (last)
	);

	always begin
		clk = 1'b0;
		#4;
		clk = 1'b1;
		#4;
	end

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count == CYCLE_LIMIT) begin
			$display("** sliding_window_arq_transmitter: FAILED **");
			$finish;
		end
	end

	// receiver stalls: the mode follows cycle_count[10:9], one mode never stalls
	always @(posedge clk) begin
		stall_lfsr <= {stall_lfsr[14:0],
			stall_lfsr[15] ^ stall_lfsr[13] ^ stall_lfsr[12] ^ stall_lfsr[10]};
		case (cycle_count[10:9])
			2'd0: out_ready <= 1'b1;
			2'd1: out_ready <= (stall_lfsr[1:0] != 2'b00);
			2'd2: out_ready <= (stall_lfsr[2:0] == 3'b000);
			default: out_ready <= 1'($urandom_range(0, 1));
		endcase
	end

	always @(posedge clk)
		if (arst_n && out_valid && out_ready)
			sb.check_result(kind, channel, seqno, payload_out, last);

	task automatic write_reg(logic [APB_AW-1:0] addr, logic [APB_DW-1:0] value);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= addr;
		pwdata <= value;
		@(posedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
		if (addr == ADDR_CHANNEL_ID)
			sb.chan_cfg = value[CHAN_W-1:0];
		else
			sb.retx_cfg = value[TICKS_W-1:0];
		@(posedge clk);
	endtask

	task automatic send_item(logic [CMD_W-1:0] cmd, logic [HANDLE_W-1:0] hd,
			logic [SEQ_W-1:0] ack);
		in_valid <= 1'b1;
		command <= cmd;
		payload_handle <= hd;
		ack_seqno <= ack;
		do @(posedge clk); while (!in_ready);
		sb.note_command(cmd, hd, ack);
	endtask

	// hold the sender until every expected frame is out, then let the walk finish
	task automatic drain();
		in_valid <= 1'b0;
		while (sb.frames_due.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic configure(logic [CHAN_W-1:0] ch, logic [TICKS_W-1:0] ticks);
		drain();
		write_reg(ADDR_CHANNEL_ID, APB_DW'(ch));
		write_reg(ADDR_RETX_TICKS, APB_DW'(ticks));
	endtask

	task automatic directed_items();
		send_item(CMD_FIRST_UNUSED, 16'hFFFF, 32'hFFFF_FFFF);
		send_item(CMD_MID_UNUSED, 16'h0000, 32'h0000_0000);
		send_item(CMD_LAST_UNUSED, 16'hA5A5, 32'h5A5A_5A5A);
		send_item(CMD_DATA, 16'h0000, 32'hFFFF_FFFF);
		send_item(CMD_DATA, 16'hFFFF, 32'h0000_0000);
		send_item(CMD_TICK, 16'h0000, 32'h0000_0000);
		send_item(CMD_TICK, 16'hFFFF, 32'hFFFF_FFFF);
		// quenched network: store and rearm, send no data frames
		send_item(CMD_QUENCH, 16'h0000, 32'h0000_0000);
		send_item(CMD_DATA, 16'h1234, 32'h0000_0000);
		send_item(CMD_TICK, 16'h0000, 32'h0000_0000);
		send_item(CMD_TICK, 16'h0000, 32'h0000_0000);
		send_item(CMD_UNQUENCH, 16'h0000, 32'h0000_0000);
		// fill the window, then overflow it
		for (int i = 0; i < WINDOW_SIZE_DEF - 3; i++)
			send_item(CMD_DATA, 16'(16'h8000 + i), 32'h0000_0000);
		send_item(CMD_DATA, 16'hBEEF, 32'h0000_0000);
		send_item(CMD_ACK, 16'h0000, 32'hFFFF_FFFF);
		send_item(CMD_ACK, 16'h0000, 32'h0000_0000);
		send_item(CMD_ACK, 16'h0000, SEQ_RESET);
		send_item(CMD_TICK, 16'h0000, 32'h0000_0000);
		send_item(CMD_TICK, 16'h0000, 32'h0000_0000);
		send_item(CMD_ACK, 16'h0000, SEQ_RESET + 1);
		send_item(CMD_DATA, 16'h7FFF, 32'h0000_0000);
		send_item(CMD_DATA, 16'h4321, 32'h0000_0000);
	endtask

	task automatic pick_item(output logic [CMD_W-1:0] cmd, output logic [HANDLE_W-1:0] hd,
			output logic [SEQ_W-1:0] ack);
		int unsigned r;
		int unsigned pick;
		r = $urandom_range(0, 99);
		pick = $urandom_range(0, 4);
		if ($urandom_range(0, 9) == 0)
			hd = $urandom_range(0, 1) ? 16'hFFFF : 16'h0000;
		else
			hd = 16'($urandom);
		ack = $urandom;
		if (r < 40)
			cmd = CMD_DATA;
		else if (r < 62) begin
			cmd = CMD_ACK;
			// mostly acks of stored items, the rest stale or stray numbers
			if (pick == 4)
				ack = sb.next_seq;
			else if (pick != 0 && sb.held != 0)
				ack = sb.random_held_seqno();
		end else if (r < 80)
			cmd = CMD_TICK;
		else if (r < 86)
			cmd = CMD_QUENCH;
		else if (r < 93)
			cmd = CMD_UNQUENCH;
		else
			cmd = CMD_W'($urandom_range(CMD_FIRST_UNUSED, CMD_LAST_UNUSED));
	endtask

	task automatic random_items(int unsigned count);
		int unsigned done;
		int unsigned burst;
		int unsigned gap;
		logic [CMD_W-1:0]    cmd;
		logic [HANDLE_W-1:0] hd;
		logic [SEQ_W-1:0]    ack;
		done = 0;
		burst = 0;
		while (done < count) begin
			if (burst == 0) begin
				burst = $urandom_range(1, 16);
				gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
				if (gap != 0) begin
					in_valid <= 1'b0;
					repeat (gap) @(posedge clk);
				end
			end
			pick_item(cmd, hd, ack);
			send_item(cmd, hd, ack);
			burst--;
			if (cmd <= CMD_TICK)
				done++;
		end
		in_valid <= 1'b0;
	endtask

	initial begin
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		repeat (2) @(posedge clk);

		configure(8'hA5, 16'd2);
		directed_items();

		configure(8'hFF, 16'd1);
		random_items(30);
		drain();
		random_items(30);

		configure(8'h00, 16'd3);
		random_items(60);

		configure(8'h5A, 16'hFFFF);
		random_items(50);

		configure(8'h11, 16'd0);
		random_items(50);

		drain();
		if (sb.mismatches == 0 && sb.frames_due.size() == 0) begin
			$display("** sliding_window_arq_transmitter: PASSED **");
		end else begin
			if (sb.frames_due.size() != 0)
				$display("%0d expected frames never arrived", sb.frames_due.size());
			$display("** sliding_window_arq_transmitter: FAILED **");
		end
		$finish;
	end

endmodule
